// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the queue's RTL modules.
// Users provide clk_i and rst_ni in the module scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PMQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pmq_pkg.sv =====
// Shared constants, types and helpers of the priority message queue.
// No dependencies; every module file refers to it by scoped names.
package pmq_pkg;

  localparam int QUEUE_DEPTH     = 8;
  localparam int PRIORITY_LEVELS = 5;
  localparam int HANDLE_WIDTH    = 32;

  localparam int HANDLE_IO_W = 32;
  localparam int STORE_W     = (HANDLE_WIDTH < HANDLE_IO_W) ? HANDLE_WIDTH : HANDLE_IO_W;
  localparam int LVL_W       = $clog2(PRIORITY_LEVELS);
  localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int MEM_DEPTH   = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int PRIO_W      = 3;
  localparam int LIMIT_W     = 6;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int MODES_W     = MODE_W * PRIORITY_LEVELS;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W  = $clog2(CMD_FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(CMD_FIFO_DEPTH + 1);

  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(PRIORITY_LEVELS - 1);
  localparam logic [LVL_W-1:0]  LVL_BOTTOM = '0;
  localparam logic [LVL_W-1:0]  LVL_MID   = LVL_W'(2);
  localparam logic [LVL_W-1:0]  LVL_MID_UP = LVL_W'(3);
  localparam logic [LVL_W-1:0]  LVL_LOW_UP = LVL_W'(1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_DROP     = 2'd0,
    MODE_COALESCE = 2'd1,
    MODE_HOLD     = 2'd2,
    MODE_DELIVER  = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISCARDED = 2'd0,
    KIND_DELIVERED = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_LOCKED_MODES = 2'd0,
    REG_GAMING_MODES = 2'd1,
    REG_LOCKED_FLAG  = 2'd2,
    REG_GAMING_FLAG  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [MODES_W-1:0] locked_modes;
    logic [MODES_W-1:0] gaming_modes;
    logic               locked_flag;
    logic               gaming_flag;
  } cfg_t;

  typedef struct packed {
    op_e                        op;
    logic [STORE_W-1:0]         handle;
    logic [LVL_W-1:0]           lvl;
    mode_e                      mode;
    logic [PRIORITY_LEVELS-1:0] deliver;
    logic [LIMIT_W-1:0]         limit;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [LVL_W-1:0] lvl,
                                                logic [HEAD_W-1:0] slot);
    return ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(slot));
  endfunction

endpackage

// ===== hdl/pmq_regs.sv =====
// APB-style configuration registers: mode tables and flags.
// Depends on pmq_pkg.
module pmq_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pmq_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pmq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pmq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pmq_pkg::cfg_t                    cfg_o
);

  pmq_pkg::cfg_t      cfg_q, cfg_d;
  pmq_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = pmq_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        pmq_pkg::REG_LOCKED_MODES: cfg_d.locked_modes = pwdata[pmq_pkg::MODES_W-1:0];
        pmq_pkg::REG_GAMING_MODES: cfg_d.gaming_modes = pwdata[pmq_pkg::MODES_W-1:0];
        pmq_pkg::REG_LOCKED_FLAG:  cfg_d.locked_flag  = pwdata[0];
        pmq_pkg::REG_GAMING_FLAG:  cfg_d.gaming_flag  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pmq_pkg::REG_LOCKED_MODES: prdata = pmq_pkg::APB_DATA_W'(cfg_q.locked_modes);
      pmq_pkg::REG_GAMING_MODES: prdata = pmq_pkg::APB_DATA_W'(cfg_q.gaming_modes);
      pmq_pkg::REG_LOCKED_FLAG:  prdata = pmq_pkg::APB_DATA_W'(cfg_q.locked_flag);
      pmq_pkg::REG_GAMING_FLAG:  prdata = pmq_pkg::APB_DATA_W'(cfg_q.gaming_flag);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.locked_modes <= '1;
      cfg_q.gaming_modes <= '1;
      cfg_q.locked_flag  <= 1'b0;
      cfg_q.gaming_flag  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/pmq_front.sv =====
// Front end: accepts input items, maps priority to a level and resolves
// the suspension modes into a command for the back end. Depends on pmq_pkg.
module pmq_front (
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [pmq_pkg::HANDLE_IO_W-1:0]    message_handle_i,
  input  logic signed [pmq_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic [pmq_pkg::LIMIT_W-1:0]        max_count_i,
  input  pmq_pkg::cfg_t                      cfg_i,
  input  logic                               fifo_full_i,
  output logic                               push_o,
  output pmq_pkg::cmd_t                      cmd_o
);

  pmq_pkg::mode_e             modes [pmq_pkg::PRIORITY_LEVELS];
  logic [pmq_pkg::LVL_W-1:0]  lvl;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // Out-of-range priorities clamp to the nearest level.
  always_comb begin
    lvl = pmq_pkg::LVL_MID;
    unique case (priority_req_i) inside
      3'b010, 3'b011:         lvl = pmq_pkg::LVL_TOP;
      3'b001:                 lvl = pmq_pkg::LVL_MID_UP;
      3'b000:                 lvl = pmq_pkg::LVL_MID;
      3'b111:                 lvl = pmq_pkg::LVL_LOW_UP;
      3'b100, 3'b101, 3'b110: lvl = pmq_pkg::LVL_BOTTOM;
      default:                lvl = pmq_pkg::LVL_MID;
    endcase
  end

  always_comb begin
    for (int i = 0; i < pmq_pkg::PRIORITY_LEVELS; i++) begin
      if (cfg_i.locked_flag) begin
        modes[i] = pmq_pkg::mode_e'(cfg_i.locked_modes[pmq_pkg::MODE_W*i +: pmq_pkg::MODE_W]);
      end else if (cfg_i.gaming_flag) begin
        modes[i] = pmq_pkg::mode_e'(cfg_i.gaming_modes[pmq_pkg::MODE_W*i +: pmq_pkg::MODE_W]);
      end else begin
        modes[i] = pmq_pkg::MODE_DELIVER;
      end
    end
  end

  always_comb begin
    cmd_o.op     = pmq_pkg::op_e'(operation_i);
    cmd_o.handle = pmq_pkg::STORE_W'(message_handle_i);
    cmd_o.lvl    = lvl;
    cmd_o.mode   = modes[lvl];
    cmd_o.limit  = max_count_i;
    for (int i = 0; i < pmq_pkg::PRIORITY_LEVELS; i++) begin
      cmd_o.deliver[i] = (modes[i] == pmq_pkg::MODE_DELIVER);
    end
  end

endmodule

// ===== hdl/pmq_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on pmq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pmq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pmq_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pmq_pkg::cmd_t cmd_o
);

  pmq_pkg::cmd_t                    slots_q [pmq_pkg::CMD_FIFO_DEPTH];
  logic [pmq_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pmq_pkg::FIFO_CNT_W-1:0]   count_q, count_d;

  localparam logic [pmq_pkg::FIFO_PTR_W-1:0] PtrLast =
    pmq_pkg::FIFO_PTR_W'(pmq_pkg::CMD_FIFO_DEPTH - 1);
  localparam logic [pmq_pkg::FIFO_CNT_W-1:0] CntFull =
    pmq_pkg::FIFO_CNT_W'(pmq_pkg::CMD_FIFO_DEPTH);

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `PMQ_ASSERT(a_fifo_bound, 1'b1, count_q <= CntFull, "command queue over capacity")
  `PMQ_ASSERT(a_fifo_pop_nonempty, pop_i, count_q != '0, "pop from empty command queue")
  `PMQ_ASSERT_NEXT(a_fifo_grow, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

// ===== hdl/pmq_back.sv =====
// Back end: per-level FIFOs in one handle memory, head and count registers,
// sequencer for enqueue, coalesce and dequeue, and the result register.
// Depends on pmq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pmq_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  pmq_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pmq_pkg::KIND_W-1:0]      kind_o,
  output logic [pmq_pkg::HANDLE_IO_W-1:0] message_handle_res_o,
  output logic                            last_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_DEQ   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  localparam int PL = pmq_pkg::PRIORITY_LEVELS;

  state_e state_q, state_d;

  logic [pmq_pkg::HEAD_W-1:0]  heads_q  [PL];
  logic [pmq_pkg::HEAD_W-1:0]  heads_d  [PL];
  logic [pmq_pkg::CNT_W-1:0]   counts_q [PL];
  logic [pmq_pkg::CNT_W-1:0]   counts_d [PL];

  logic [pmq_pkg::STORE_W-1:0] mem_q [pmq_pkg::MEM_DEPTH];
  logic [pmq_pkg::STORE_W-1:0] rdata_q;
  logic                        mem_we, mem_re;
  logic [pmq_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [pmq_pkg::STORE_W-1:0] mem_wdata;

  pmq_pkg::cmd_t               cmd_q, cmd_d;
  logic [pmq_pkg::LIMIT_W-1:0] limit_q, limit_d;
  pmq_pkg::kind_e              kind_q, kind_d;
  logic                        last_q, last_d;

  logic                        out_valid_q, out_valid_d;
  pmq_pkg::kind_e              out_kind_q, out_kind_d;
  logic [pmq_pkg::STORE_W-1:0] out_handle_q, out_handle_d;
  logic                        out_last_q, out_last_d;
  logic                        out_free, out_load;

  logic [PL-1:0]               avail, remain;
  logic [pmq_pkg::LVL_W-1:0]   pick, sel_lvl;
  logic [pmq_pkg::HEAD_W-1:0]  sel_head, head_next, tail_slot;
  logic [pmq_pkg::CNT_W-1:0]   sel_cnt;
  logic [pmq_pkg::SUM_W-1:0]   tail_sum;
  logic                        unlimited, lim_ok, deq_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign unlimited = (cmd_q.limit == '0);
  assign lim_ok    = unlimited || (limit_q != '0);

  always_comb begin
    pick = '0;
    for (int i = 0; i < PL; i++) begin
      avail[i] = cmd_q.deliver[i] && (counts_q[i] != '0);
      if (avail[i]) begin
        pick = pmq_pkg::LVL_W'(i);
      end
    end
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: sel_lvl = cmd_i.lvl;
      ST_DEQ:  sel_lvl = pick;
      default: sel_lvl = cmd_q.lvl;
    endcase
  end

  assign sel_head  = heads_q[sel_lvl];
  assign sel_cnt   = counts_q[sel_lvl];
  assign head_next = (sel_head == pmq_pkg::HEAD_LAST) ? '0 : sel_head + 1'b1;
  assign tail_sum  = pmq_pkg::SUM_W'(sel_head) + pmq_pkg::SUM_W'(sel_cnt);
  assign tail_slot = (tail_sum >= pmq_pkg::SUM_W'(pmq_pkg::QUEUE_DEPTH)) ?
                     pmq_pkg::HEAD_W'(tail_sum - pmq_pkg::SUM_W'(pmq_pkg::QUEUE_DEPTH)) :
                     pmq_pkg::HEAD_W'(tail_sum);

  // A level that empties with this pop leaves the remaining set.
  always_comb begin
    remain = avail;
    if (sel_cnt == pmq_pkg::CNT_W'(1)) begin
      remain[pick] = 1'b0;
    end
  end
  assign deq_last = (remain == '0) || (!unlimited && limit_q == pmq_pkg::LIMIT_W'(1));

  always_comb begin
    state_d      = state_q;
    heads_d      = heads_q;
    counts_d     = counts_q;
    cmd_d        = cmd_q;
    limit_d      = limit_q;
    kind_d       = kind_q;
    last_d       = last_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = pmq_pkg::mem_addr(sel_lvl, tail_slot);
    mem_raddr    = pmq_pkg::mem_addr(sel_lvl, sel_head);
    mem_wdata    = cmd_i.handle;
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_handle_d = out_handle_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == pmq_pkg::OP_DEQ) begin
            cmd_pop_o = 1'b1;
            cmd_d     = cmd_i;
            limit_d   = cmd_i.limit;
            state_d   = ST_DEQ;
          end else begin
            case (cmd_i.mode)
              pmq_pkg::MODE_DROP: begin
                if (out_free) begin
                  out_load     = 1'b1;
                  out_kind_d   = pmq_pkg::KIND_DISCARDED;
                  out_handle_d = cmd_i.handle;
                  out_last_d   = 1'b1;
                  cmd_pop_o    = 1'b1;
                end
              end
              pmq_pkg::MODE_COALESCE: begin
                cmd_pop_o = 1'b1;
                if (sel_cnt == '0) begin
                  mem_we            = 1'b1;
                  mem_waddr         = pmq_pkg::mem_addr(sel_lvl, '0);
                  heads_d[sel_lvl]  = '0;
                  counts_d[sel_lvl] = pmq_pkg::CNT_W'(1);
                end else begin
                  cmd_d   = cmd_i;
                  state_d = ST_DRAIN;
                end
              end
              default: begin
                if (sel_cnt >= pmq_pkg::CNT_FULL) begin
                  if (out_free) begin
                    out_load     = 1'b1;
                    out_kind_d   = pmq_pkg::KIND_OVERFLOW;
                    out_handle_d = cmd_i.handle;
                    out_last_d   = 1'b1;
                    cmd_pop_o    = 1'b1;
                  end
                end else begin
                  mem_we            = 1'b1;
                  counts_d[sel_lvl] = sel_cnt + 1'b1;
                  cmd_pop_o         = 1'b1;
                end
              end
            endcase
          end
        end
      end

      ST_DRAIN: begin
        // Pop the head; on the final pop also park the new handle in slot 0.
        // The memory reads before it writes, so the old slot 0 still comes out.
        mem_re            = 1'b1;
        heads_d[sel_lvl]  = head_next;
        counts_d[sel_lvl] = sel_cnt - 1'b1;
        kind_d            = pmq_pkg::KIND_DISCARDED;
        last_d            = (sel_cnt == pmq_pkg::CNT_W'(1));
        if (sel_cnt == pmq_pkg::CNT_W'(1)) begin
          mem_we            = 1'b1;
          mem_waddr         = pmq_pkg::mem_addr(sel_lvl, '0);
          mem_wdata         = cmd_q.handle;
          heads_d[sel_lvl]  = '0;
          counts_d[sel_lvl] = pmq_pkg::CNT_W'(1);
        end
        state_d = ST_EMIT;
      end

      ST_DEQ: begin
        if ((avail != '0) && lim_ok) begin
          mem_re            = 1'b1;
          heads_d[sel_lvl]  = head_next;
          counts_d[sel_lvl] = sel_cnt - 1'b1;
          if (!unlimited) begin
            limit_d = limit_q - 1'b1;
          end
          kind_d  = pmq_pkg::KIND_DELIVERED;
          last_d  = deq_last;
          state_d = ST_EMIT;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = pmq_pkg::KIND_NONE;
          out_handle_d = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = kind_q;
          out_handle_d = rdata_q;
          out_last_d   = last_q;
          if (last_q) begin
            state_d = ST_IDLE;
          end else if (cmd_q.op == pmq_pkg::OP_DEQ) begin
            state_d = ST_DEQ;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Handle memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    limit_q      <= limit_d;
    kind_q       <= kind_d;
    last_q       <= last_d;
    out_kind_q   <= out_kind_d;
    out_handle_q <= out_handle_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PL; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
      counts_q    <= counts_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign kind_o               = out_kind_q;
  assign message_handle_res_o = pmq_pkg::HANDLE_IO_W'(out_handle_q);
  assign last_o               = out_last_q;

  `PMQ_ASSERT(a_drain_nonempty, state_q == ST_DRAIN, sel_cnt != '0, "coalesce drain on empty level")
  `PMQ_ASSERT(a_pop_in_idle, cmd_pop_o, state_q == ST_IDLE, "command taken while busy")
  `PMQ_ASSERT_NEXT(a_emit_loads, state_q == ST_EMIT && out_free, out_valid_q, "pending item lost")

endmodule

// ===== hdl/priority_message_queue_with_suspension.sv =====
// Top level of the priority message queue with suspension modes.
// Depends on pmq_pkg, pmq_regs, pmq_front, pmq_cmd_fifo and pmq_back.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o    | operation_i, message_handle_i,
//          |                            | priority_req_i, max_count_i
//  out     | out_valid_o / out_ready_i  | kind_o, message_handle_res_o, last_o
//  cfg     | psel, penable, pwrite,     | paddr, pwdata, prdata
//          | pready                     |
//
// An accepted item is registered in the command queue before the back end sees it. An
// append, a drop and an overflow are handled in the idle state; a dequeue or a coalesce
// of a non-empty level first takes the command from the queue, then per handle reads the
// memory with registered data and loads the result, or it loads the none marker.
// After reset all levels are empty at once; the handle memory is not cleared.
// A stalled result holds the back end while the two-entry command queue fills.
module priority_message_queue_with_suspension (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [pmq_pkg::HANDLE_IO_W-1:0]   message_handle_i,
  input  logic signed [pmq_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [pmq_pkg::LIMIT_W-1:0]       max_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pmq_pkg::KIND_W-1:0]        kind_o,
  output logic [pmq_pkg::HANDLE_IO_W-1:0]   message_handle_res_o,
  output logic                              last_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pmq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pmq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  pmq_pkg::cfg_t cfg;
  pmq_pkg::cmd_t front_cmd, queued_cmd;
  logic          fifo_full, push, cmd_valid, cmd_pop;

  pmq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmq_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .message_handle_i (message_handle_i),
    .priority_req_i   (priority_req_i),
    .max_count_i      (max_count_i),
    .cfg_i            (cfg),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .cmd_o            (front_cmd)
  );

  pmq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (queued_cmd)
  );

  pmq_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (queued_cmd),
    .cmd_pop_o            (cmd_pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .kind_o               (kind_o),
    .message_handle_res_o (message_handle_res_o),
    .last_o               (last_o)
  );

endmodule

// ===== sim/priority_message_queue_with_suspension_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for priority_message_queue_with_suspension: mirrors the five
// priority FIFOs and the suspension tables, and checks every notice and register read.
// Depends on pmq_pkg and the top level only.
module priority_message_queue_with_suspension_tb;

  typedef struct {
    pmq_pkg::kind_e                  kind;
    logic [pmq_pkg::HANDLE_IO_W-1:0] handle;
    logic                            last;
  } notice_t;

  logic                                clk_i            = 1'b0;
  logic                                rst_ni           = 1'b0;
  logic                                in_valid_i       = 1'b0;
  logic                                operation_i      = 1'b0;
  logic [pmq_pkg::HANDLE_IO_W-1:0]     message_handle_i = '0;
  logic signed [pmq_pkg::PRIO_W-1:0]   priority_req_i   = '0;
  logic [pmq_pkg::LIMIT_W-1:0]         max_count_i      = '0;
  logic                                out_ready_i      = 1'b0;
  logic                                psel             = 1'b0;
  logic                                penable          = 1'b0;
  logic                                pwrite           = 1'b0;
  logic [pmq_pkg::APB_ADDR_W-1:0]      paddr            = '0;
  logic [pmq_pkg::APB_DATA_W-1:0]      pwdata           = '0;
  logic                                in_ready_o;
  logic                                out_valid_o;
  logic [pmq_pkg::KIND_W-1:0]          kind_o;
  logic [pmq_pkg::HANDLE_IO_W-1:0]     message_handle_res_o;
  logic                                last_o;
  logic [pmq_pkg::APB_DATA_W-1:0]      prdata;
  logic                                pready;

  priority_message_queue_with_suspension dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .message_handle_i,
    .priority_req_i, .max_count_i, .out_valid_o, .out_ready_i, .kind_o,
    .message_handle_res_o, .last_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  // Mirror of the queue contents and the mode registers
  logic [pmq_pkg::HANDLE_IO_W-1:0] fifo_slots [pmq_pkg::PRIORITY_LEVELS][pmq_pkg::QUEUE_DEPTH];
  int unsigned                     fifo_head  [pmq_pkg::PRIORITY_LEVELS];
  int unsigned                     fifo_fill  [pmq_pkg::PRIORITY_LEVELS];
  logic [pmq_pkg::MODES_W-1:0]     locked_table = '1;
  logic [pmq_pkg::MODES_W-1:0]     gaming_table = '1;
  logic                            locked_on    = 1'b0;
  logic                            gaming_on    = 1'b0;

  notice_t     due_notices[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned dequeues_sent = 0;
  int unsigned notices_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned kind_tally [4] = '{0, 0, 0, 0};
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);

  function automatic int unsigned level_of(logic signed [pmq_pkg::PRIO_W-1:0] prio);
    // saturate priorities outside -2..2
    if (prio < -2) return 0;
    if (prio > 2) return pmq_pkg::PRIORITY_LEVELS - 1;
    return int'(prio) + 2;
  endfunction

  function automatic pmq_pkg::mode_e mode_of(int unsigned lvl);
    if (locked_on) return pmq_pkg::mode_e'(locked_table[2*lvl +: pmq_pkg::MODE_W]);
    if (gaming_on) return pmq_pkg::mode_e'(gaming_table[2*lvl +: pmq_pkg::MODE_W]);
    return pmq_pkg::MODE_DELIVER;
  endfunction

  function automatic logic [pmq_pkg::HANDLE_IO_W-1:0] pop_level(int unsigned lvl);
    logic [pmq_pkg::HANDLE_IO_W-1:0] h;
    h = fifo_slots[lvl][fifo_head[lvl]];
    fifo_head[lvl] = (fifo_head[lvl] + 1) % pmq_pkg::QUEUE_DEPTH;
    fifo_fill[lvl]--;
    return h;
  endfunction

  // Update the mirror for one accepted item and queue the notices it causes
  function automatic void predict_notices(pmq_pkg::op_e op,
                                          logic [pmq_pkg::HANDLE_IO_W-1:0] handle,
                                          logic signed [pmq_pkg::PRIO_W-1:0] prio,
                                          logic [pmq_pkg::LIMIT_W-1:0] limit);
    notice_t     batch[$];
    int unsigned lvl;
    int unsigned left;
    logic        unlimited;
    if (op == pmq_pkg::OP_ENQ) begin
      lvl = level_of(prio);
      case (mode_of(lvl))
        pmq_pkg::MODE_DROP: batch.push_back('{pmq_pkg::KIND_DISCARDED, handle, 1'b0});
        pmq_pkg::MODE_COALESCE: begin
          while (fifo_fill[lvl] != 0)
            batch.push_back('{pmq_pkg::KIND_DISCARDED, pop_level(lvl), 1'b0});
          fifo_head[lvl] = 0;
          fifo_slots[lvl][0] = handle;
          fifo_fill[lvl] = 1;
        end
        default: begin
          if (fifo_fill[lvl] >= pmq_pkg::QUEUE_DEPTH) begin
            batch.push_back('{pmq_pkg::KIND_OVERFLOW, handle, 1'b0});
          end else begin
            fifo_slots[lvl][(fifo_head[lvl] + fifo_fill[lvl]) % pmq_pkg::QUEUE_DEPTH] = handle;
            fifo_fill[lvl]++;
          end
        end
      endcase
    end else begin
      left = limit;
      unlimited = (limit == 0);
      for (int l = pmq_pkg::PRIORITY_LEVELS - 1; l >= 0; l--) begin
        if (mode_of(l) == pmq_pkg::MODE_DELIVER) begin
          while (fifo_fill[l] != 0 && (unlimited || left != 0)) begin
            batch.push_back('{pmq_pkg::KIND_DELIVERED, pop_level(l), 1'b0});
            if (!unlimited) left--;
          end
        end
      end
      if (batch.size() == 0) batch.push_back('{pmq_pkg::KIND_NONE, '0, 1'b0});
    end
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) begin
      kind_tally[batch[i].kind]++;
      due_notices.push_back(batch[i]);
    end
  endfunction

  always @(posedge clk_i) begin
    notice_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      notices_checked++;
      if (due_notices.size() == 0) begin
        $display("%0t: unexpected notice: expected none, got kind %0d handle %h last %0d",
                 $time, kind_o, message_handle_res_o, last_o);
        mismatches++;
      end else begin
        want = due_notices.pop_front();
        if (kind_o !== want.kind) begin
          $display("%0t: kind: expected %0d, got %0d", $time, want.kind, kind_o);
          mismatches++;
        end
        if (message_handle_res_o !== want.handle) begin
          $display("%0t: handle: expected %h, got %h", $time, want.handle,
                   message_handle_res_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last: expected %0d, got %0d", $time, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(pmq_pkg::op_e op, logic [pmq_pkg::HANDLE_IO_W-1:0] handle,
                           int prio, int limit);
    logic signed [pmq_pkg::PRIO_W-1:0] prio_bits;
    logic [pmq_pkg::LIMIT_W-1:0]       limit_bits;
    prio_bits  = pmq_pkg::PRIO_W'(prio);
    limit_bits = pmq_pkg::LIMIT_W'(limit);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    message_handle_i <= handle;
    priority_req_i   <= prio_bits;
    max_count_i      <= limit_bits;
    do @(posedge clk_i); while (!in_ready_o);
    predict_notices(op, handle, prio_bits, limit_bits);
    items_sent++;
    if (op == pmq_pkg::OP_DEQ) dequeues_sent++;
  endtask

  // Write a register, then read it straight back
  task automatic set_register(pmq_pkg::reg_idx_e idx, logic [pmq_pkg::APB_DATA_W-1:0] value);
    logic [pmq_pkg::APB_DATA_W-1:0] readback;
    logic                           done;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pmq_pkg::APB_ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pmq_pkg::REG_LOCKED_MODES: locked_table = value[pmq_pkg::MODES_W-1:0];
      pmq_pkg::REG_GAMING_MODES: gaming_table = value[pmq_pkg::MODES_W-1:0];
      pmq_pkg::REG_LOCKED_FLAG:  locked_on    = value[0];
      pmq_pkg::REG_GAMING_FLAG:  gaming_on    = value[0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      readback = prdata;
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, value,
               readback);
      mismatches++;
    end
    reg_writes++;
  endtask

  task automatic apply_settings(logic [pmq_pkg::MODES_W-1:0] lm,
                                logic [pmq_pkg::MODES_W-1:0] gm,
                                logic lf, logic gf);
    set_register(pmq_pkg::REG_LOCKED_MODES, pmq_pkg::APB_DATA_W'(lm));
    set_register(pmq_pkg::REG_GAMING_MODES, pmq_pkg::APB_DATA_W'(gm));
    set_register(pmq_pkg::REG_LOCKED_FLAG, pmq_pkg::APB_DATA_W'(lf));
    set_register(pmq_pkg::REG_GAMING_FLAG, pmq_pkg::APB_DATA_W'(gf));
  endtask

  task automatic drain_notices();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_notices.size() != 0);
  endtask

  // Appends leave no notice behind, so give the back end time to finish them
  task automatic wait_quiet();
    drain_notices();
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [pmq_pkg::MODES_W-1:0] pick_modes();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return pmq_pkg::MODES_W'($urandom);
    endcase
  endfunction

  task automatic test_deliver_basics();
    send_item(pmq_pkg::OP_ENQ, 32'h0000_0000, -4, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hFFFF_FFFF, -3, 63);
    send_item(pmq_pkg::OP_ENQ, 32'hAAAA_AAAA, -2, 0);
    send_item(pmq_pkg::OP_ENQ, 32'h5555_5555, -1, 0);
    send_item(pmq_pkg::OP_ENQ, 32'h0000_0001, 0, 0);
    send_item(pmq_pkg::OP_ENQ, 32'h8000_0000, 1, 0);
    send_item(pmq_pkg::OP_ENQ, 32'h1234_5678, 2, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hFEDC_BA98, 3, 0);
    send_item(pmq_pkg::OP_DEQ, 32'hFFFF_FFFF, 0, 0);
  endtask

  task automatic test_overflow_and_limits();
    for (int i = 0; i <= pmq_pkg::QUEUE_DEPTH; i++)
      send_item(pmq_pkg::OP_ENQ, 32'hC0DE_0000 + i, 2, 0);
    send_item(pmq_pkg::OP_DEQ, '0, 0, 3);
    send_item(pmq_pkg::OP_DEQ, '0, 0, 63);
  endtask

  task automatic test_suspension_modes();
    wait_quiet();
    set_register(pmq_pkg::REG_LOCKED_MODES,
                 pmq_pkg::APB_DATA_W'({pmq_pkg::MODE_COALESCE, pmq_pkg::MODE_DELIVER,
                                       pmq_pkg::MODE_HOLD, pmq_pkg::MODE_COALESCE,
                                       pmq_pkg::MODE_DROP}));
    set_register(pmq_pkg::REG_GAMING_MODES,
                 pmq_pkg::APB_DATA_W'({pmq_pkg::PRIORITY_LEVELS{pmq_pkg::MODE_DROP}}));
    set_register(pmq_pkg::REG_LOCKED_FLAG, 1);
    set_register(pmq_pkg::REG_GAMING_FLAG, 1);
    send_item(pmq_pkg::OP_ENQ, 32'hD0D0_0001, -2, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hC0A1_0001, -1, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hC0A1_0002, -1, 0);
    send_item(pmq_pkg::OP_ENQ, 32'h401D_0001, 0, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hC0A1_0004, 2, 0);
    send_item(pmq_pkg::OP_DEQ, '0, 0, 0);
    // gaming table takes over once unlocked
    wait_quiet();
    set_register(pmq_pkg::REG_LOCKED_FLAG, 0);
    send_item(pmq_pkg::OP_ENQ, 32'hD0D0_0002, 0, 0);
    // release everything that was held or coalesced
    wait_quiet();
    set_register(pmq_pkg::REG_GAMING_FLAG, 0);
    send_item(pmq_pkg::OP_DEQ, '0, 0, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_by_phase [4];
    int unsigned stall_by_phase [4];
    int unsigned enq_pct;
    int unsigned pick;
    int          limit;
    idle_by_phase  = '{0, 76, 0, 16};
    stall_by_phase = '{0, 0, 76, 16};
    for (int round = 0; round < 12; round++) begin
      wait_quiet();
      case (round)
        0:       apply_settings('1, '0, 1'b1, 1'b0);
        1:       apply_settings('0, '1, 1'b1, 1'b1);
        2:       apply_settings('0, '1, 1'b0, 1'b1);
        3:       apply_settings('1, '0, 1'b0, 1'b1);
        default: apply_settings(pick_modes(), pick_modes(), 1'($urandom_range(1)),
                                1'($urandom_range(1)));
      endcase
      sender_idle_pct    = idle_by_phase[round % 4];
      receiver_stall_pct = stall_by_phase[round % 4];
      enq_pct = $urandom_range(55, 85);
      for (int n = 0; n < 34; n++) begin
        // hold off the sender until the block has answered everything
        if (n == 17 && round % 3 == 0) drain_notices();
        if ($urandom_range(99) < enq_pct) begin
          send_item(pmq_pkg::OP_ENQ, $urandom, $urandom_range(7), $urandom_range(63));
        end else begin
          pick = $urandom_range(9);
          if (pick < 3) limit = 0;
          else if (pick < 8) limit = $urandom_range(1, 9);
          else limit = $urandom_range(63);
          send_item(pmq_pkg::OP_DEQ, $urandom, $urandom_range(7), limit);
        end
      end
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_deliver_basics();
    test_overflow_and_limits();
    test_suspension_modes();
    test_random_traffic();
    drain_notices();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d items (%0d dequeues), %0d notices checked, %0d register writes.",
             items_sent, dequeues_sent, notices_checked, reg_writes);
    $display("Notices by kind: discarded %0d, delivered %0d, overflow %0d, none %0d.",
             kind_tally[pmq_pkg::KIND_DISCARDED], kind_tally[pmq_pkg::KIND_DELIVERED],
             kind_tally[pmq_pkg::KIND_OVERFLOW], kind_tally[pmq_pkg::KIND_NONE]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d notices outstanding", due_notices.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pmq_pkg.sv
hdl/pmq_regs.sv
hdl/pmq_front.sv
hdl/pmq_cmd_fifo.sv
hdl/pmq_back.sv
hdl/priority_message_queue_with_suspension.sv
sim/priority_message_queue_with_suspension_tb.sv
